// ----- rtl/gcs_pkg.sv -----
// ----------------------------------------------------------------------------
// gcs_pkg
// Shared constants, types and helpers for the Goedel Christoffel symbol block.
// ----------------------------------------------------------------------------
package gcs_pkg;

	// Number formats.
	localparam int IN_FRAC_BITS = 28;
	localparam int OUT_FRAC     = 28;
	localparam int COORD_W      = 32;
	localparam int VAL_W        = 48;
	localparam int IDX_W        = 4;
	localparam int NUM_SYM      = 13;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SYM - 1);

	// Squares carry twice the input fraction; brackets are held in Q62.
	localparam int F2    = 2 * IN_FRAC_BITS;
	localparam int SH_L  = (F2 <= 62) ? 62 - F2 : 0;
	localparam int SH_R  = (F2 > 62) ? F2 - 62 : 0;
	localparam int SQ_W  = 64;
	localparam int DEN_W = ((F2 > 63) ? F2 : 63) + 2;
	localparam int NUM_W = DEN_W;
	localparam int REM_W = DEN_W + 1;
	localparam int QUO_W = 63;
	localparam int BR_W  = 68 + SH_L;

	// Long division: one quotient bit per step.
	localparam int DIV_STEPS = QUO_W;
	localparam int DIV_PER   = 4;
	localparam int DIV_STG   = (DIV_STEPS + DIV_PER - 1) / DIV_PER;

	// Final multiplier, cut into 32 x 32 partial products.
	localparam int A_W  = BR_W - 1;
	localparam int B_W  = 64;
	localparam int P_W  = A_W + B_W;
	localparam int A_CH = (A_W + 31) / 32;
	localparam int B_CH = B_W / 32;
	localparam int R_W  = P_W - 33;

	localparam logic [B_W-1:0] SQRT2_Q62 = 64'h5A82_7999_FCEF_3242;

	// Fraction bits of the product in each mode, and the rounding shifts.
	localparam int SH_DIR   = 62 - OUT_FRAC;
	localparam int SH_ROOT  = 94 - OUT_FRAC;
	localparam int SH_SCALE = 62 + IN_FRAC_BITS - OUT_FRAC;

	localparam logic [VAL_W-1:0] VAL_MAX_POS = {1'b0, {(VAL_W-1){1'b1}}};

	// Symbol numbers in order of first appearance.
	localparam logic [IDX_W-1:0] SYM_XD     = 4'd0;
	localparam logic [IDX_W-1:0] SYM_XY_SUM = 4'd1;
	localparam logic [IDX_W-1:0] SYM_YY_Q   = 4'd2;
	localparam logic [IDX_W-1:0] SYM_YD     = 4'd3;
	localparam logic [IDX_W-1:0] SYM_XX_P   = 4'd4;
	localparam logic [IDX_W-1:0] SYM_XY_D   = 4'd5;
	localparam logic [IDX_W-1:0] SYM_X_YM   = 4'd6;
	localparam logic [IDX_W-1:0] SYM_Y_YQ   = 4'd7;
	localparam logic [IDX_W-1:0] SYM_DIFF   = 4'd8;
	localparam logic [IDX_W-1:0] SYM_Y_XP   = 4'd9;
	localparam logic [IDX_W-1:0] SYM_X_YQ   = 4'd10;
	localparam logic [IDX_W-1:0] SYM_X_XP   = 4'd11;
	localparam logic [IDX_W-1:0] SYM_Y_XM   = 4'd12;

	typedef enum logic [1:0] {
		MODE_DIR,
		MODE_ROOT,
		MODE_SCALE
	} mode_t;

	// One symbol on its way into the divider.
	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		mode_t              mode;
		logic               flip;
		logic               dbl;
		logic               num_neg;
		logic [NUM_W-1:0]   num;
		logic [DEN_W-1:0]   den;
		logic [BR_W-1:0]    add;
		logic [COORD_W-1:0] coord;
	} op_t;

	// One symbol leaving the divider.
	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		mode_t              mode;
		logic               flip;
		logic               dbl;
		logic               num_neg;
		logic [BR_W-1:0]    add;
		logic [COORD_W-1:0] coord;
		logic [QUO_W-1:0]   quo;
	} quo_t;

	// Square with F2 fraction bits moved to Q62.
	function automatic logic [BR_W-1:0] to62(input logic [SQ_W-1:0] v);
		logic [BR_W-1:0] w;
		w = BR_W'(v);
		return (w << SH_L) >> SH_R;
	endfunction

endpackage

// ----- rtl/gcs_if.sv -----
// ----------------------------------------------------------------------------
// gcs_pos_if / gcs_sym_if
// Valid/ready channels for positions in and symbols out.
// ----------------------------------------------------------------------------
interface gcs_pos_if import gcs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;

	modport source (output valid, output pos_x, output pos_y, input ready);
	modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface gcs_sym_if import gcs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [IDX_W-1:0]        symbol_index;
	logic signed [VAL_W-1:0] symbol_value;
	logic                    last_symbol;

	modport source (output valid, output symbol_index, output symbol_value,
		output last_symbol, input ready);
	modport sink   (input valid, input symbol_index, input symbol_value,
		input last_symbol, output ready);
endinterface

// ----- rtl/gcs_front.sv -----
// ----------------------------------------------------------------------------
// gcs_front
// Request buffer, symbol sequencer and operand preparation (three stages).
// ----------------------------------------------------------------------------
module gcs_front import gcs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	gcs_pos_if.sink pos,
	input  logic  adv,
	output op_t   op_s3,
	output logic  v_s3
);

	logic                      buf_v_q;
	logic signed [COORD_W-1:0] buf_x_q, buf_y_q;
	logic                      cur_v_q;
	logic signed [COORD_W-1:0] cur_x_q, cur_y_q;
	logic [IDX_W-1:0]          cnt_q;
	logic                      load;

	logic                      v_s1, v_s2;
	logic [IDX_W-1:0]          idx_s1, idx_s2;
	logic                      sx_s1, sy_s1, sx_s2, sy_s2;
	logic [COORD_W-1:0]        ax_s1, ay_s1, ax_s2, ay_s2;
	logic [SQ_W-1:0]           xx_s2, yy_s2, xy_s2;

	op_t                       op_nx;
	logic [DEN_W-1:0]          s2c;
	logic signed [NUM_W:0]     p_v, q_v, xm_v, ym_v, dd_v, t;
	logic                      csign, sxy;

	assign pos.ready = ~buf_v_q;
	assign load = buf_v_q && (!cur_v_q || (adv && cnt_q == LAST_IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_v_q <= 1'b0;
			cur_v_q <= 1'b0;
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			if (pos.valid && pos.ready) begin
				buf_v_q <= 1'b1;
			end else if (load) begin
				buf_v_q <= 1'b0;
			end
			if (load) begin
				cur_v_q <= 1'b1;
				cnt_q   <= '0;
			end else if (adv && cur_v_q) begin
				if (cnt_q == LAST_IDX) begin
					cur_v_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (adv) begin
				v_s1 <= cur_v_q;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
		end
	end

	// Operand arithmetic for the selected symbol.
	always_comb begin
		s2c   = DEN_W'(1) << F2;
		sxy   = sx_s2 ^ sy_s2;
		p_v   = (NUM_W+1)'(s2c) + (NUM_W+1)'(xx_s2);
		q_v   = (NUM_W+1)'(s2c) + (NUM_W+1)'(yy_s2);
		xm_v  = (NUM_W+1)'(xx_s2) - (NUM_W+1)'(s2c);
		ym_v  = (NUM_W+1)'(yy_s2) - (NUM_W+1)'(s2c);
		dd_v  = (NUM_W+1)'(xx_s2) - (NUM_W+1)'(yy_s2);
		t     = '0;
		csign = 1'b0;
		op_nx       = '0;
		op_nx.idx   = idx_s2;
		op_nx.mode  = MODE_DIR;
		op_nx.den   = s2c + DEN_W'(xx_s2) + DEN_W'(yy_s2);
		case (idx_s2)
			SYM_XD: begin
				t = (NUM_W+1)'(ax_s2) << IN_FRAC_BITS;
				csign = sx_s2;
				op_nx.dbl = 1'b1;
			end
			SYM_XY_SUM: begin
				t = (NUM_W+1)'(xy_s2);
				op_nx.add  = to62(xy_s2);
				op_nx.flip = ~sxy;
				op_nx.mode = MODE_ROOT;
			end
			SYM_YY_Q: begin
				t = q_v;
				op_nx.add  = to62(yy_s2);
				op_nx.flip = 1'b1;
				op_nx.mode = MODE_ROOT;
			end
			SYM_YD: begin
				t = (NUM_W+1)'(ay_s2) << IN_FRAC_BITS;
				csign = sy_s2;
				op_nx.dbl = 1'b1;
			end
			SYM_XX_P: begin
				t = p_v;
				op_nx.add  = to62(xx_s2);
				op_nx.mode = MODE_ROOT;
			end
			SYM_XY_D: begin
				t = (NUM_W+1)'(xy_s2);
				op_nx.dbl  = 1'b1;
				op_nx.flip = ~sxy;
				op_nx.mode = MODE_ROOT;
			end
			SYM_X_YM: begin
				t = ym_v;
				op_nx.add   = to62({yy_s2[SQ_W-2:0], 1'b0});
				op_nx.flip  = sx_s2;
				op_nx.coord = ax_s2;
				op_nx.mode  = MODE_SCALE;
			end
			SYM_Y_YQ: begin
				t = q_v;
				op_nx.add   = to62({yy_s2[SQ_W-2:0], 1'b0});
				op_nx.flip  = sy_s2;
				op_nx.coord = ay_s2;
				op_nx.mode  = MODE_SCALE;
			end
			SYM_DIFF: begin
				t = dd_v;
				op_nx.mode = MODE_ROOT;
			end
			SYM_Y_XP: begin
				t = p_v;
				op_nx.add   = to62({xx_s2[SQ_W-2:0], 1'b0});
				op_nx.flip  = ~sy_s2;
				op_nx.coord = ay_s2;
				op_nx.mode  = MODE_SCALE;
			end
			SYM_X_YQ: begin
				t = q_v;
				op_nx.add   = to62({yy_s2[SQ_W-2:0], 1'b0});
				op_nx.flip  = ~sx_s2;
				op_nx.coord = ax_s2;
				op_nx.mode  = MODE_SCALE;
			end
			SYM_X_XP: begin
				t = p_v;
				op_nx.add   = to62({xx_s2[SQ_W-2:0], 1'b0});
				op_nx.flip  = sx_s2;
				op_nx.coord = ax_s2;
				op_nx.mode  = MODE_SCALE;
			end
			SYM_Y_XM: begin
				t = xm_v;
				op_nx.add   = to62({xx_s2[SQ_W-2:0], 1'b0});
				op_nx.flip  = sy_s2;
				op_nx.coord = ay_s2;
				op_nx.mode  = MODE_SCALE;
			end
			default: begin
			end
		endcase
		op_nx.num_neg = t[NUM_W] ^ csign;
		op_nx.num     = t[NUM_W] ? NUM_W'(-t) : NUM_W'(t);
	end

	always_ff @(posedge clk) begin
		if (pos.valid && pos.ready) begin
			buf_x_q <= pos.pos_x;
			buf_y_q <= pos.pos_y;
		end
		if (load) begin
			cur_x_q <= buf_x_q;
			cur_y_q <= buf_y_q;
		end
		if (adv) begin
			idx_s1 <= cnt_q;
			sx_s1  <= cur_x_q[COORD_W-1];
			sy_s1  <= cur_y_q[COORD_W-1];
			ax_s1  <= cur_x_q[COORD_W-1] ? COORD_W'(-cur_x_q) : COORD_W'(cur_x_q);
			ay_s1  <= cur_y_q[COORD_W-1] ? COORD_W'(-cur_y_q) : COORD_W'(cur_y_q);
			idx_s2 <= idx_s1;
			sx_s2  <= sx_s1;
			sy_s2  <= sy_s1;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			xx_s2  <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
			yy_s2  <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
			xy_s2  <= SQ_W'(ax_s1) * SQ_W'(ay_s1);
			op_s3  <= op_nx;
		end
	end

	a_load_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (cur_v_q && cnt_q == '0))
		else $error("sequencer did not restart on a new position");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_v_q |-> (cnt_q <= LAST_IDX))
		else $error("symbol counter out of range");

	a_buffer_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(buf_v_q && !load) |=> buf_v_q)
		else $error("buffered position lost");

endmodule

// ----- rtl/gcs_div.sv -----
// ----------------------------------------------------------------------------
// gcs_div
// Pipelined restoring divider giving each ratio to D in Q62.
// ----------------------------------------------------------------------------
module gcs_div import gcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  op_t  op_in,
	input  logic v_in,
	output quo_t res,
	output logic v_out
);

	op_t              op_q  [DIV_STG];
	logic [REM_W-1:0] rem_q [DIV_STG];
	logic [QUO_W-1:0] quo_q [DIV_STG];
	logic             v_q   [DIV_STG];

	for (genvar g = 0; g < DIV_STG; g++) begin : g_stg
		localparam int FIRST = g * DIV_PER;
		localparam int CNT   = (DIV_STEPS - FIRST < DIV_PER) ? DIV_STEPS - FIRST : DIV_PER;

		op_t              op_i;
		logic             v_i;
		logic [REM_W-1:0] r_i, r_n;
		logic [QUO_W-1:0] q_i, q_n;

		if (g == 0) begin : g_head
			assign op_i = op_in;
			assign v_i  = v_in;
			assign r_i  = REM_W'(op_in.num);
			assign q_i  = '0;
		end else begin : g_body
			assign op_i = op_q[g-1];
			assign v_i  = v_q[g-1];
			assign r_i  = rem_q[g-1];
			assign q_i  = quo_q[g-1];
		end

		always_comb begin
			r_n = r_i;
			q_n = q_i;
			for (int i = 0; i < CNT; i++) begin
				if (FIRST + i != 0) begin
					r_n = r_n << 1;
					q_n = q_n << 1;
				end
				if (r_n >= REM_W'(op_i.den)) begin
					r_n    = r_n - REM_W'(op_i.den);
					q_n[0] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[g] <= 1'b0;
			end else if (adv) begin
				v_q[g] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				op_q[g]  <= op_i;
				rem_q[g] <= r_n;
				quo_q[g] <= q_n;
			end
		end
	end

	always_comb begin
		res.idx     = op_q[DIV_STG-1].idx;
		res.mode    = op_q[DIV_STG-1].mode;
		res.flip    = op_q[DIV_STG-1].flip;
		res.dbl     = op_q[DIV_STG-1].dbl;
		res.num_neg = op_q[DIV_STG-1].num_neg;
		res.add     = op_q[DIV_STG-1].add;
		res.coord   = op_q[DIV_STG-1].coord;
		res.quo     = quo_q[DIV_STG-1];
	end
	assign v_out = v_q[DIV_STG-1];

endmodule

// ----- rtl/gcs_back.sv -----
// ----------------------------------------------------------------------------
// gcs_back
// Bracket sum, split multiplier, rounding and saturation, output register.
// ----------------------------------------------------------------------------
module gcs_back import gcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  quo_t res,
	input  logic v_in,
	output logic adv,
	gcs_sym_if.source sym
);

	logic                  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, o_v_q;
	logic [IDX_W-1:0]      idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6, o_idx_q;
	mode_t                 mode_s1, mode_s2, mode_s3, mode_s4, mode_s5;
	logic                  flip_s1;
	logic                  neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [COORD_W-1:0]    coord_s1;
	logic [BR_W-1:0]       br_s1, rmag;
	logic [A_W-1:0]        a_s2, mag;
	logic [B_W-1:0]        b_s2;
	logic [63:0]           pp_s3 [A_CH][B_CH];
	logic [P_W-1:0]        sum_s4 [B_CH];
	logic [P_W-1:0]        prod_s5;
	logic [R_W-1:0]        rnd_s6, rnd_nx;
	logic [A_CH*32-1:0]    a_pad;
	logic [P_W:0]          s_dir, s_root, s_scale;
	logic [R_W-1:0]        sat_m;
	logic [VAL_W-1:0]      o_val_q;

	// Partial products that share one half of the second operand.
	function automatic logic [P_W-1:0] psum(input int j);
		logic [P_W-1:0] s;
		s = '0;
		for (int i = 0; i < A_CH; i++) begin
			s = s + (P_W'(pp_s3[i][j]) << (32 * i));
		end
		return s;
	endfunction

	assign adv = ~o_v_q | sym.ready;

	assign rmag  = res.dbl ? (BR_W'(res.quo) << 1) : BR_W'(res.quo);
	assign mag   = br_s1[BR_W-1] ? A_W'(-br_s1) : A_W'(br_s1);
	assign a_pad = (A_CH*32)'(a_s2);

	always_comb begin
		s_dir   = {1'b0, prod_s5} + ((P_W+1)'(1) << (SH_DIR - 1));
		s_root  = {1'b0, prod_s5} + ((P_W+1)'(1) << (SH_ROOT - 1));
		s_scale = {1'b0, prod_s5} + ((P_W+1)'(1) << (SH_SCALE - 1));
		case (mode_s5)
			MODE_DIR:   rnd_nx = R_W'(s_dir >> SH_DIR);
			MODE_ROOT:  rnd_nx = R_W'(s_root >> SH_ROOT);
			MODE_SCALE: rnd_nx = R_W'(s_scale >> SH_SCALE);
			default:    rnd_nx = '0;
		endcase
	end

	always_comb begin
		sat_m = rnd_s6;
		if (neg_s6) begin
			if (rnd_s6 > R_W'(VAL_MAX_POS) + 1'b1) begin
				sat_m = R_W'(VAL_MAX_POS) + 1'b1;
			end
		end else if (rnd_s6 > R_W'(VAL_MAX_POS)) begin
			sat_m = R_W'(VAL_MAX_POS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			o_v_q <= 1'b0;
		end else if (adv) begin
			v_s1  <= v_in;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			o_v_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1   <= res.idx;
			mode_s1  <= res.mode;
			flip_s1  <= res.flip;
			coord_s1 <= res.coord;
			br_s1    <= res.num_neg ? res.add - rmag : res.add + rmag;

			idx_s2  <= idx_s1;
			mode_s2 <= mode_s1;
			neg_s2  <= br_s1[BR_W-1] ^ flip_s1;
			a_s2    <= (mode_s1 == MODE_ROOT) ? (mag >> 30) : mag;
			case (mode_s1)
				MODE_DIR:   b_s2 <= B_W'(1);
				MODE_ROOT:  b_s2 <= SQRT2_Q62;
				MODE_SCALE: b_s2 <= B_W'(coord_s1);
				default:    b_s2 <= '0;
			endcase

			idx_s3  <= idx_s2;
			mode_s3 <= mode_s2;
			neg_s3  <= neg_s2;
			for (int i = 0; i < A_CH; i++) begin
				for (int j = 0; j < B_CH; j++) begin
					pp_s3[i][j] <= 64'(a_pad[i*32 +: 32]) * 64'(b_s2[j*32 +: 32]);
				end
			end

			idx_s4  <= idx_s3;
			mode_s4 <= mode_s3;
			neg_s4  <= neg_s3;
			for (int j = 0; j < B_CH; j++) begin
				sum_s4[j] <= psum(j);
			end

			idx_s5  <= idx_s4;
			mode_s5 <= mode_s4;
			neg_s5  <= neg_s4;
			prod_s5 <= sum_s4[0] + (sum_s4[1] << 32);

			idx_s6 <= idx_s5;
			neg_s6 <= neg_s5;
			rnd_s6 <= rnd_nx;

			o_idx_q <= idx_s6;
			o_val_q <= neg_s6 ? VAL_W'(-sat_m) : VAL_W'(sat_m);
		end
	end

	assign sym.valid        = o_v_q;
	assign sym.symbol_index = o_idx_q;
	assign sym.symbol_value = o_val_q;
	assign sym.last_symbol  = (o_idx_q == LAST_IDX);

endmodule

// ----- rtl/goedel_christoffel_symbols.sv -----
// ----------------------------------------------------------------------------
// goedel_christoffel_symbols
// Thirteen Christoffel symbols of the scaled Goedel metric per position.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Payload                                   Per request
// pos      in         pos_x, pos_y (signed Q3.28)               one position
// sym      out        symbol_index, symbol_value (Q19.28),      one symbol
//                     last_symbol
//
// Each position yields thirteen symbol requests, one per cycle while the result
// port does not stall; the single result port sets how often a new position
// is taken. A symbol's way from its position runs mostly through the sixteen
// stages of the Q62 long divider.
// Reset is asynchronous and clears every valid bit; nothing else needs it.
// A stall on the result port freezes the whole pipeline, while a one-deep
// position buffer still takes the next position.
//
// Structure: the front end buffers the position, steps through the thirteen
// symbols and prepares the squares, the denominator 1 + X^2 + Y^2 and the
// numerator of each ratio. The divider produces the ratio four quotient bits
// per stage (three in the last). The back end adds the polynomial term,
// multiplies by sqrt2, by the coordinate or by one in 32-bit partial products,
// rounds to nearest with ties away from zero and saturates to 48 bits.
module goedel_christoffel_symbols import gcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	gcs_pos_if.sink   pos,
	gcs_sym_if.source sym
);

	op_t  op_s3;
	logic v_s3;
	quo_t div_res;
	logic div_v;
	logic adv;

	gcs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pos    (pos),
		.adv    (adv),
		.op_s3  (op_s3),
		.v_s3   (v_s3)
	);

	gcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.op_in  (op_s3),
		.v_in   (v_s3),
		.res    (div_res),
		.v_out  (div_v)
	);

	gcs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (div_res),
		.v_in   (div_v),
		.adv    (adv),
		.sym    (sym)
	);

endmodule

// ----- test/gcs_symbol_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gcs_symbol_checker
// Watches both channels of the Christoffel symbol block, works out the
// thirteen symbols of every accepted position and compares each symbol
// request against them in order.
// ----------------------------------------------------------------------------
module gcs_symbol_checker import gcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	gcs_pos_if        pos,
	gcs_sym_if        sym,
	output int        errors,
	output int        outstanding
);

	typedef logic [127:0] w128_t;

	typedef struct {
		logic [IDX_W-1:0] index;
		logic [VAL_W-1:0] value;
		logic             last;
	} symbol_t;

	symbol_t awaited_symbols[$];

	function automatic w128_t with_sign(w128_t m, logic neg);
		return neg ? -m : m;
	endfunction

	function automatic w128_t magnitude(w128_t v);
		return v[127] ? -v : v;
	endfunction

	// Signed quotient in Q62, magnitude floored.
	function automatic w128_t q62_ratio(w128_t num, w128_t den);
		logic neg;
		w128_t r;
		logic [63:0] q;
		neg = num[127];
		r = magnitude(num);
		q = 0;
		if (r >= den) begin
			r = r - den;
			q = 1;
		end
		for (int i = 0; i < 62; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		return with_sign({64'd0, q}, neg);
	endfunction

	function automatic w128_t square_to_q62(w128_t m);
		if (2 * IN_FRAC_BITS <= 62)
			return m << (62 - 2 * IN_FRAC_BITS);
		return m >> (2 * IN_FRAC_BITS - 62);
	endfunction

	// Q62 bracket cut to Q32 and multiplied by sqrt2, giving Q94.
	function automatic w128_t times_root2(w128_t v);
		w128_t m;
		m = magnitude(v) >> 30;
		return with_sign(w128_t'(m[63:0]) * w128_t'(SQRT2_Q62), v[127]);
	endfunction

	function automatic w128_t times_coord(w128_t v, logic [63:0] a, logic s);
		return with_sign(magnitude(v) * w128_t'(a), v[127] ^ s);
	endfunction

	// Round to nearest, ties away from zero, then saturate to 48 bits.
	function automatic logic [VAL_W-1:0] rounded_value(w128_t v, int frac);
		int sh;
		w128_t m;
		sh = frac - OUT_FRAC;
		m = (magnitude(v) + (w128_t'(1) << (sh - 1))) >> sh;
		if (v[127]) begin
			if (m > w128_t'(VAL_MAX_POS) + 1)
				m = w128_t'(VAL_MAX_POS) + 1;
			return VAL_W'(-m);
		end
		if (m > w128_t'(VAL_MAX_POS))
			m = w128_t'(VAL_MAX_POS);
		return VAL_W'(m);
	endfunction

	// All thirteen symbol values of one position, symbol 0 in the low bits.
	function automatic logic [NUM_SYM*VAL_W-1:0] christoffel_values(
		logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		logic sx, sy, sxy;
		logic [63:0] ax, ay;
		w128_t xx, yy, axy, s2, den, xd, yd, rxy, p, q, xm, ym, dd;
		w128_t x2, y2, x2d, y2d;
		logic [NUM_SYM*VAL_W-1:0] v;
		int fa;
		sx = x[COORD_W-1];
		sy = y[COORD_W-1];
		sxy = sx ^ sy;
		ax = sx ? 64'(-x) & 64'hFFFF_FFFF : 64'(x) & 64'hFFFF_FFFF;
		ay = sy ? 64'(-y) & 64'hFFFF_FFFF : 64'(y) & 64'hFFFF_FFFF;
		fa = 62 + IN_FRAC_BITS;
		xx = w128_t'(ax) * w128_t'(ax);
		yy = w128_t'(ay) * w128_t'(ay);
		axy = w128_t'(ax) * w128_t'(ay);
		s2 = w128_t'(1) << (2 * IN_FRAC_BITS);
		den = s2 + xx + yy;
		xd = q62_ratio(with_sign(w128_t'(ax) << IN_FRAC_BITS, sx), den);
		yd = q62_ratio(with_sign(w128_t'(ay) << IN_FRAC_BITS, sy), den);
		rxy = q62_ratio(axy, den);
		p = q62_ratio(s2 + xx, den);
		q = q62_ratio(s2 + yy, den);
		xm = q62_ratio(xx - s2, den);
		ym = q62_ratio(yy - s2, den);
		dd = q62_ratio(xx - yy, den);
		x2 = square_to_q62(xx);
		y2 = square_to_q62(yy);
		x2d = square_to_q62(xx << 1);
		y2d = square_to_q62(yy << 1);
		v[SYM_XD*VAL_W +: VAL_W]     = rounded_value(xd << 1, 62);
		v[SYM_XY_SUM*VAL_W +: VAL_W] = rounded_value(
			-times_root2(with_sign(square_to_q62(axy) + rxy, sxy)), 94);
		v[SYM_YY_Q*VAL_W +: VAL_W]   = rounded_value(-times_root2(y2 + q), 94);
		v[SYM_YD*VAL_W +: VAL_W]     = rounded_value(yd << 1, 62);
		v[SYM_XX_P*VAL_W +: VAL_W]   = rounded_value(times_root2(x2 + p), 94);
		v[SYM_XY_D*VAL_W +: VAL_W]   = rounded_value(
			-times_root2(with_sign(rxy, sxy) << 1), 94);
		v[SYM_X_YM*VAL_W +: VAL_W]   = rounded_value(times_coord(y2d + ym, ax, sx), fa);
		v[SYM_Y_YQ*VAL_W +: VAL_W]   = rounded_value(times_coord(y2d + q, ay, sy), fa);
		v[SYM_DIFF*VAL_W +: VAL_W]   = rounded_value(times_root2(dd), 94);
		v[SYM_Y_XP*VAL_W +: VAL_W]   = rounded_value(-times_coord(x2d + p, ay, sy), fa);
		v[SYM_X_YQ*VAL_W +: VAL_W]   = rounded_value(-times_coord(y2d + q, ax, sx), fa);
		v[SYM_X_XP*VAL_W +: VAL_W]   = rounded_value(times_coord(x2d + p, ax, sx), fa);
		v[SYM_Y_XM*VAL_W +: VAL_W]   = rounded_value(times_coord(x2d + xm, ay, sy), fa);
		return v;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t: symbol mismatch: %s", $realtime, what);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [NUM_SYM*VAL_W-1:0] vals;
		symbol_t s;
		if (!arst_n) begin
			errors = 0;
			outstanding <= 0;
			awaited_symbols.delete();
		end else begin
			if (pos.valid && pos.ready) begin
				vals = christoffel_values(pos.pos_x, pos.pos_y);
				for (int k = 0; k < NUM_SYM; k++) begin
					s.index = IDX_W'(k);
					s.value = vals[k*VAL_W +: VAL_W];
					s.last  = (IDX_W'(k) == LAST_IDX);
					awaited_symbols = {awaited_symbols, s};
				end
			end
			if (sym.valid && sym.ready) begin
				if (awaited_symbols.size() == 0) begin
					report_mismatch($sformatf("unexpected symbol %0d",
						sym.symbol_index));
				end else begin
					s = awaited_symbols.pop_front();
					if (sym.symbol_index !== s.index)
						report_mismatch($sformatf("index %0d, expected %0d",
							sym.symbol_index, s.index));
					if (sym.symbol_value !== s.value)
						report_mismatch($sformatf("symbol %0d value %h, expected %h",
							s.index, sym.symbol_value, s.value));
					if (sym.last_symbol !== s.last)
						report_mismatch($sformatf("symbol %0d last %b, expected %b",
							s.index, sym.last_symbol, s.last));
				end
			end
			outstanding <= awaited_symbols.size();
		end
	end

endmodule

// ----- test/goedel_christoffel_symbols_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// goedel_christoffel_symbols_test
// Drives positions into the Christoffel symbol block under bursty traffic
// and a stalling receiver; the checker beside it predicts every symbol.
// ----------------------------------------------------------------------------
module goedel_christoffel_symbols_test;
	import gcs_pkg::*;

	localparam int RANDOM_POSITIONS = 450;
	localparam int IDLE_LIMIT       = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors;
	int   outstanding;
	int   idle_cycles = 0;

	gcs_pos_if pos ();
	gcs_sym_if sym ();

	goedel_christoffel_symbols dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pos    (pos),
		.sym    (sym)
	);

	gcs_symbol_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.pos         (pos),
		.sym         (sym),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// A 4 ns clock, high and low for 2 ns each.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The receiver changes its manner every so often: sometimes it takes every
	// symbol, sometimes it stalls at random, and sometimes it stalls in long
	// regular stretches so that the whole pipeline freezes for a while.
	int stall_style = 0;
	int style_left  = 0;
	int phase       = 0;

	always @(posedge clk) begin
		if (style_left == 0) begin
			stall_style <= $urandom_range(0, 2);
			style_left  <= $urandom_range(20, 200);
		end else begin
			style_left <= style_left - 1;
		end
		phase <= phase + 1;
		if (!arst_n)
			sym.ready <= 1'b0;
		else case (stall_style)
			0: sym.ready <= 1'b1;
			1: sym.ready <= ($urandom_range(0, 3) != 0);
			default: sym.ready <= ((phase % 23) < 15);
		endcase
	end

	// The watchdog ends the run when no request moves on either channel for
	// far longer than the block could ever need.
	always @(posedge clk) begin
		if ((pos.valid && pos.ready) || (sym.valid && sym.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Bursts of positions: after each accepted request the sender either
	// carries straight on or drops valid for a random gap.
	int burst_left = 0;

	task automatic send_position(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		logic taken;
		pos.valid <= 1'b1;
		pos.pos_x <= x;
		pos.pos_y <= y;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = pos.ready;
			@(posedge clk);
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			if ($urandom_range(0, 2) != 0) begin
				pos.valid <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	endtask

	// Coordinates of small, moderate or full-range size, with a random sign.
	function automatic logic [COORD_W-1:0] random_coord();
		logic [COORD_W-1:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom();
			1: v = $urandom_range(0, 32'h0FFF_FFFF);
			2: v = $urandom_range(0, 32'h3FFF_FFFF);
			3: v = $urandom_range(0, 255);
			4: v = $urandom_range(32'h7FFF_0000, 32'h7FFF_FFFF);
			default: v = $urandom_range(0, 32'h1FFF_FFFF);
		endcase
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	localparam logic [COORD_W-1:0] ONE   = 32'h1000_0000;
	localparam logic [COORD_W-1:0] MAXC  = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] MINC  = 32'h8000_0000;

	initial begin
		pos.valid = 1'b0;
		pos.pos_x = '0;
		pos.pos_y = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed positions: the origin, where many symbols are zero; the
		// extremes of both coordinates, where the cubic symbols are largest;
		// unit points and the smallest steps away from zero.
		send_position('0, '0);
		send_position(MAXC, MAXC);
		send_position(MINC, MINC);
		send_position(MAXC, MINC);
		send_position(MINC, MAXC);
		send_position(MAXC, '0);
		send_position('0, MINC);
		send_position(32'd1, '0);
		send_position('0, 32'd1);
		send_position(-32'sd1, -32'sd1);
		send_position(ONE, '0);
		send_position('0, ONE);
		send_position(-ONE, ONE);
		send_position(ONE, ONE);
		send_position(-ONE, -ONE);
		send_position(32'h1800_0000, -32'sh1800_0000);
		send_position(32'h5555_5555, 32'hAAAA_AAAA);
		send_position(32'hAAAA_AAAA, 32'h5555_5555);
		send_position(32'h2000_0000, 32'h2000_0000);
		send_position(32'h6000_0000, -32'sh6000_0000);

		for (int i = 0; i < RANDOM_POSITIONS; i++)
			send_position(random_coord(), random_coord());
		pos.valid <= 1'b0;
		@(posedge clk);

		// Let every outstanding symbol drain, then keep watching the symbol
		// channel in case anything stray follows.
		while (outstanding != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		if (errors == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
